// ===== hdl/cwfd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the complex wavelet FIR decimator: codes, field widths, defaults,
// the sequencer state type and the control struct from sequencer to datapath.
// Depends on nothing.
package cwfd_pkg;

  localparam int MAX_HALF_DEF    = 63;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COEF_BITS_DEF   = 18;

  localparam int FRAC_SHIFT = 17;
  localparam int OP_W       = 2;
  localparam int INDEX_W    = 6;
  localparam int HALF_CFG_W = 6;
  localparam int STEP_W     = 11;
  localparam int COUNT_W    = 16;
  localparam int OUT_W      = 32;
  localparam int POWER_W    = 63;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  localparam logic [STEP_W-1:0] STEP_MAX = 11'd1024;

  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  localparam logic [1:0] REG_HALF  = 2'd0;
  localparam logic [1:0] REG_STEP  = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_SAT,
    ST_SQUARE,
    ST_EMIT
  } seq_state_e;

  typedef struct packed {
    logic issue;
    logic first;
    logic last;
    logic sat_en;
    logic sq_en;
  } mac_ctrl_t;

endpackage

// ===== hdl/cwfd_ram.sv =====
`timescale 1ns / 1ps
// Generic synchronous RAM with one write port and two registered read ports.
// Depends on nothing.
module cwfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== hdl/cwfd_mac.sv =====
`timescale 1ns / 1ps
// Datapath of the decimator: tap pair pre-add, complex multiply-accumulate,
// shift and saturation, squared magnitude. Depends on cwfd_pkg.
module cwfd_mac #(
  parameter int SAMPLE_BITS = cwfd_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = cwfd_pkg::COEF_BITS_DEF,
  parameter int MAX_HALF    = cwfd_pkg::MAX_HALF_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cwfd_pkg::mac_ctrl_t               ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0]     l_i,
  input  logic signed [SAMPLE_BITS-1:0]     r_i,
  input  logic signed [COEF_BITS-1:0]       re_tap_i,
  input  logic signed [COEF_BITS-1:0]       im_tap_i,
  output logic                              done_o,
  output logic signed [cwfd_pkg::OUT_W-1:0] re_o,
  output logic signed [cwfd_pkg::OUT_W-1:0] im_o,
  output logic [cwfd_pkg::POWER_W-1:0]      power_o
);

  localparam int SUM_W  = SAMPLE_BITS + 1;
  localparam int PROD_W = SUM_W + COEF_BITS;
  localparam int ACC_W  = PROD_W + $clog2(MAX_HALF + 1) + 1;
  localparam int SH_MIN = cwfd_pkg::OUT_W + 1 + cwfd_pkg::FRAC_SHIFT;
  localparam int SH_W   = (ACC_W > SH_MIN) ? ACC_W : SH_MIN;
  localparam int SQ_W   = 2 * cwfd_pkg::OUT_W;

  localparam logic signed [SH_W-1:0] SAT_HI = SH_W'(32'sh7FFFFFFF);
  localparam logic signed [SH_W-1:0] SAT_LO = SH_W'(32'sh80000000);

  logic v1_q, f1_q, e1_q;
  logic v2_q, f2_q, e2_q;
  logic v3_q, f3_q, e3_q;

  logic signed [SUM_W-1:0]     sum_q, diff_q;
  logic signed [COEF_BITS-1:0] re_c_q, im_c_q;
  logic signed [PROD_W-1:0]    pre_q, pim_q;
  logic signed [ACC_W-1:0]     acc_re_q, acc_re_d, acc_im_q, acc_im_d;
  logic signed [cwfd_pkg::OUT_W-1:0] re_q, im_q;
  logic [cwfd_pkg::POWER_W-1:0] pr_q, pi_q;
  logic signed [SQ_W-1:0]      sq_re, sq_im;
  logic [SQ_W-1:0]             pw_sum;

  function automatic logic signed [cwfd_pkg::OUT_W-1:0] sat_shift(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [SH_W-1:0] ext;
    logic signed [SH_W-1:0] sh;
    ext = SH_W'(acc);
    sh  = ext >>> cwfd_pkg::FRAC_SHIFT;
    if (sh > SAT_HI) begin
      sat_shift = 32'sh7FFFFFFF;
    end else if (sh < SAT_LO) begin
      sat_shift = 32'sh80000000;
    end else begin
      sat_shift = sh[cwfd_pkg::OUT_W-1:0];
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      f1_q <= 1'b0;
      e1_q <= 1'b0;
      v2_q <= 1'b0;
      f2_q <= 1'b0;
      e2_q <= 1'b0;
      v3_q <= 1'b0;
      f3_q <= 1'b0;
      e3_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.issue;
      f1_q <= ctrl_i.first;
      e1_q <= ctrl_i.last;
      v2_q <= v1_q;
      f2_q <= f1_q;
      e2_q <= e1_q;
      v3_q <= v2_q;
      f3_q <= f2_q;
      e3_q <= e2_q;
    end
  end

  always_comb begin
    acc_re_d = acc_re_q;
    acc_im_d = acc_im_q;
    if (v3_q) begin
      if (f3_q) begin
        acc_re_d = ACC_W'(pre_q);
        acc_im_d = ACC_W'(pim_q);
      end else begin
        acc_re_d = acc_re_q + ACC_W'(pre_q);
        acc_im_d = acc_im_q + ACC_W'(pim_q);
      end
    end
  end

  assign sq_re = re_q * re_q;
  assign sq_im = im_q * im_q;

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      sum_q  <= f1_q ? SUM_W'(l_i) : SUM_W'(l_i) + SUM_W'(r_i);
      diff_q <= SUM_W'(l_i) - SUM_W'(r_i);
      re_c_q <= re_tap_i;
      im_c_q <= im_tap_i;
    end
    if (v2_q) begin
      pre_q <= sum_q * re_c_q;
      if (f2_q) begin
        pim_q <= '0;
      end else begin
        pim_q <= diff_q * im_c_q;
      end
    end
    acc_re_q <= acc_re_d;
    acc_im_q <= acc_im_d;
    if (ctrl_i.sat_en) begin
      re_q <= sat_shift(acc_re_q);
      im_q <= sat_shift(acc_im_q);
    end
    if (ctrl_i.sq_en) begin
      pr_q <= sq_re[cwfd_pkg::POWER_W-1:0];
      pi_q <= sq_im[cwfd_pkg::POWER_W-1:0];
    end
  end

  assign pw_sum  = SQ_W'(pr_q) + SQ_W'(pi_q);
  assign power_o = pw_sum[SQ_W-1] ? '1 : pw_sum[cwfd_pkg::POWER_W-1:0];
  assign done_o  = v3_q && e3_q;
  assign re_o    = re_q;
  assign im_o    = im_q;

endmodule

// ===== hdl/cwfd_seq.sv =====
`timescale 1ns / 1ps
// Sequencer of the decimator: item decode, fill and step counters, window
// pointer, tap walk and result hand-off. Depends on cwfd_pkg.
module cwfd_seq #(
  parameter int MAX_HALF = cwfd_pkg::MAX_HALF_DEF,
  localparam int WIN_DEPTH = 2 * MAX_HALF + 1,
  localparam int PTR_W     = $clog2(WIN_DEPTH),
  localparam int TAP_AW    = $clog2(MAX_HALF + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic [cwfd_pkg::OP_W-1:0]         operation_i,
  input  logic [cwfd_pkg::INDEX_W-1:0]      coef_index_i,
  input  logic [cwfd_pkg::HALF_CFG_W-1:0]   half_length_i,
  input  logic [cwfd_pkg::STEP_W-1:0]       sample_step_i,
  input  logic [cwfd_pkg::COUNT_W-1:0]      result_count_i,
  input  logic                              out_free_i,
  input  logic                              mac_done_i,
  output logic                              in_ready_o,
  output logic                              win_we_o,
  output logic [PTR_W-1:0]                  win_waddr_o,
  output logic [PTR_W-1:0]                  win_raddr_l_o,
  output logic [PTR_W-1:0]                  win_raddr_r_o,
  output logic                              tap_we_o,
  output logic [TAP_AW-1:0]                 tap_waddr_o,
  output logic [TAP_AW-1:0]                 tap_raddr_o,
  output cwfd_pkg::mac_ctrl_t               mac_ctrl_o,
  output logic                              emit_o,
  output logic [cwfd_pkg::COUNT_W-1:0]      result_index_o
);

  localparam int FILL_W = $clog2(WIN_DEPTH + 1);
  localparam int HALF_W = TAP_AW;

  cwfd_pkg::seq_state_e state_q, state_d;

  logic [PTR_W-1:0]             wp_q, wp_d;
  logic [FILL_W-1:0]            fill_q, fill_d, fill_new, len;
  logic [cwfd_pkg::STEP_W-1:0]  step_q, step_d, step_inc, step_next, step_eff;
  logic [cwfd_pkg::COUNT_W-1:0] results_q, results_d, idx_q, idx_d;
  logic [HALF_W-1:0]            h_q, h_d, j_q, j_d, h_eff;
  logic accept, is_push, is_load, is_restart, was_full, fire, emit_ok;

  assign accept     = in_valid_i && in_ready_o;
  assign is_push    = accept && (operation_i == cwfd_pkg::OP_PUSH);
  assign is_load    = accept && (operation_i == cwfd_pkg::OP_LOAD);
  assign is_restart = accept && (operation_i == cwfd_pkg::OP_RESTART);

  always_comb begin
    if (int'(half_length_i) > MAX_HALF) begin
      h_eff = HALF_W'(MAX_HALF);
    end else begin
      h_eff = HALF_W'(half_length_i);
    end
    if (sample_step_i == '0) begin
      step_eff = cwfd_pkg::STEP_W'(1);
    end else if (sample_step_i > cwfd_pkg::STEP_MAX) begin
      step_eff = cwfd_pkg::STEP_MAX;
    end else begin
      step_eff = sample_step_i;
    end
  end

  assign len      = FILL_W'({h_eff, 1'b1});
  assign fill_new = (fill_q == FILL_W'(WIN_DEPTH)) ? fill_q : fill_q + FILL_W'(1);
  assign was_full = fill_q >= len;
  assign step_inc = step_q + cwfd_pkg::STEP_W'(1);

  always_comb begin
    fire      = 1'b0;
    step_next = step_q;
    if (!was_full) begin
      if (fill_new >= len) begin
        step_next = '0;
        fire      = 1'b1;
      end
    end else if (step_inc >= step_eff) begin
      step_next = '0;
      fire      = 1'b1;
    end else begin
      step_next = step_inc;
    end
  end

  assign emit_ok = fire && (results_q < result_count_i);

  always_comb begin
    wp_d      = wp_q;
    fill_d    = fill_q;
    step_d    = step_q;
    results_d = results_q;
    h_d       = h_q;
    j_d       = j_q;
    idx_d     = idx_q;
    if (is_restart) begin
      fill_d    = '0;
      step_d    = '0;
      results_d = '0;
    end
    if (is_push) begin
      wp_d   = wp_q + PTR_W'(1);
      fill_d = fill_new;
      step_d = step_next;
      if (emit_ok) begin
        results_d = results_q + cwfd_pkg::COUNT_W'(1);
        idx_d     = results_q;
        h_d       = h_eff;
        j_d       = '0;
      end
    end
    if (state_q == cwfd_pkg::ST_RUN) begin
      j_d = j_q + HALF_W'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      cwfd_pkg::ST_IDLE: begin
        if (is_push && emit_ok) begin
          state_d = cwfd_pkg::ST_RUN;
        end
      end
      cwfd_pkg::ST_RUN: begin
        if (j_q == h_q) begin
          state_d = cwfd_pkg::ST_DRAIN;
        end
      end
      cwfd_pkg::ST_DRAIN: begin
        if (mac_done_i) begin
          state_d = cwfd_pkg::ST_SAT;
        end
      end
      cwfd_pkg::ST_SAT:    state_d = cwfd_pkg::ST_SQUARE;
      cwfd_pkg::ST_SQUARE: state_d = cwfd_pkg::ST_EMIT;
      cwfd_pkg::ST_EMIT: begin
        if (out_free_i) begin
          state_d = cwfd_pkg::ST_IDLE;
        end
      end
      default: state_d = cwfd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o        = 1'b0;
    mac_ctrl_o        = '0;
    emit_o            = 1'b0;
    case (state_q)
      cwfd_pkg::ST_IDLE: in_ready_o = 1'b1;
      cwfd_pkg::ST_RUN: begin
        mac_ctrl_o.issue = 1'b1;
        mac_ctrl_o.first = (j_q == '0);
        mac_ctrl_o.last  = (j_q == h_q);
      end
      cwfd_pkg::ST_DRAIN:  mac_ctrl_o = '0;
      cwfd_pkg::ST_SAT:    mac_ctrl_o.sat_en = 1'b1;
      cwfd_pkg::ST_SQUARE: mac_ctrl_o.sq_en = 1'b1;
      cwfd_pkg::ST_EMIT:   emit_o = out_free_i;
      default:             in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cwfd_pkg::ST_IDLE;
      wp_q      <= '0;
      fill_q    <= '0;
      step_q    <= '0;
      results_q <= '0;
      h_q       <= '0;
      j_q       <= '0;
      idx_q     <= '0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      fill_q    <= fill_d;
      step_q    <= step_d;
      results_q <= results_d;
      h_q       <= h_d;
      j_q       <= j_d;
      idx_q     <= idx_d;
    end
  end

  assign win_we_o      = is_push;
  assign win_waddr_o   = wp_q;
  assign win_raddr_l_o = wp_q - PTR_W'(1) - (PTR_W'(h_q) + PTR_W'(j_q));
  assign win_raddr_r_o = wp_q - PTR_W'(1) - (PTR_W'(h_q) - PTR_W'(j_q));
  assign tap_we_o      = is_load && (int'(coef_index_i) <= MAX_HALF);
  assign tap_waddr_o   = TAP_AW'(coef_index_i);
  assign tap_raddr_o   = j_q;
  assign result_index_o = idx_q;

endmodule

// ===== hdl/complex_wavelet_fir_decimator_core.sv =====
`timescale 1ns / 1ps
// Top level of the complex wavelet FIR decimator: configuration registers,
// sample and tap memories, sequencer, datapath and result register.
// Depends on cwfd_pkg, cwfd_ram, cwfd_seq and cwfd_mac.

// Coefficient loads, restarts and sample pushes that complete no result are
// taken without holding the input. A push that completes a result keeps the
// block busy while the sequencer walks the tap pairs one per cycle through a
// shared complex multiply-accumulate fed by the two read ports of the sample
// memory, then drains the pipeline, saturates and forms the squared magnitude.
// The finished result sits in an output register, so the next item is taken
// while it waits; a further result is held back, and the input with it, until
// that register has been read.
module complex_wavelet_fir_decimator_core #(
  parameter int MAX_HALF    = cwfd_pkg::MAX_HALF_DEF,
  parameter int SAMPLE_BITS = cwfd_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = cwfd_pkg::COEF_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cwfd_pkg::PADDR_W-1:0]      paddr,
  input  logic [cwfd_pkg::PDATA_W-1:0]      pwdata,
  output logic [cwfd_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [cwfd_pkg::OP_W-1:0]         operation_i,
  input  logic [cwfd_pkg::INDEX_W-1:0]      coef_index_i,
  input  logic signed [COEF_BITS-1:0]       coef_re_i,
  input  logic signed [COEF_BITS-1:0]       coef_im_i,
  input  logic signed [SAMPLE_BITS-1:0]     sample_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [cwfd_pkg::OUT_W-1:0] coeff_re_o,
  output logic signed [cwfd_pkg::OUT_W-1:0] coeff_im_o,
  output logic [cwfd_pkg::POWER_W-1:0]      power_o,
  output logic [cwfd_pkg::COUNT_W-1:0]      result_index_o
);

  localparam int WIN_DEPTH     = 2 * MAX_HALF + 1;
  localparam int PTR_W         = $clog2(WIN_DEPTH);
  localparam int WIN_RAM_DEPTH = 1 << PTR_W;
  localparam int TAP_DEPTH     = MAX_HALF + 1;
  localparam int TAP_AW        = $clog2(TAP_DEPTH);

  logic [cwfd_pkg::HALF_CFG_W-1:0] half_q;
  logic [cwfd_pkg::STEP_W-1:0]     step_cfg_q;
  logic [cwfd_pkg::COUNT_W-1:0]    count_q;
  logic                            cfg_we;

  logic                   win_we, tap_we, mac_done, emit_go, out_free;
  logic [PTR_W-1:0]       win_waddr, win_raddr_l, win_raddr_r;
  logic [TAP_AW-1:0]      tap_waddr, tap_raddr;
  logic [SAMPLE_BITS-1:0] win_l, win_r;
  logic [2*COEF_BITS-1:0] tap_rd, tap_rd_b;
  cwfd_pkg::mac_ctrl_t    mac_ctrl;
  logic [cwfd_pkg::COUNT_W-1:0] seq_index;

  logic signed [cwfd_pkg::OUT_W-1:0] mac_re, mac_im;
  logic [cwfd_pkg::POWER_W-1:0]      mac_power;

  logic                              out_valid_q;
  logic signed [cwfd_pkg::OUT_W-1:0] coeff_re_q, coeff_im_q;
  logic [cwfd_pkg::POWER_W-1:0]      power_q;
  logic [cwfd_pkg::COUNT_W-1:0]      result_index_q;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q     <= cwfd_pkg::HALF_CFG_W'(1);
      step_cfg_q <= cwfd_pkg::STEP_W'(1);
      count_q    <= cwfd_pkg::COUNT_W'(1);
    end else if (cfg_we) begin
      case (paddr[3:2])
        cwfd_pkg::REG_HALF:  half_q     <= pwdata[cwfd_pkg::HALF_CFG_W-1:0];
        cwfd_pkg::REG_STEP:  step_cfg_q <= pwdata[cwfd_pkg::STEP_W-1:0];
        cwfd_pkg::REG_COUNT: count_q    <= pwdata[cwfd_pkg::COUNT_W-1:0];
        default:             half_q     <= half_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      cwfd_pkg::REG_HALF:  prdata = cwfd_pkg::PDATA_W'(half_q);
      cwfd_pkg::REG_STEP:  prdata = cwfd_pkg::PDATA_W'(step_cfg_q);
      cwfd_pkg::REG_COUNT: prdata = cwfd_pkg::PDATA_W'(count_q);
      default:             prdata = '0;
    endcase
  end

  assign out_free = !out_valid_q || out_ready_i;

  cwfd_seq #(
    .MAX_HALF (MAX_HALF)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .operation_i    (operation_i),
    .coef_index_i   (coef_index_i),
    .half_length_i  (half_q),
    .sample_step_i  (step_cfg_q),
    .result_count_i (count_q),
    .out_free_i     (out_free),
    .mac_done_i     (mac_done),
    .in_ready_o     (in_ready_o),
    .win_we_o       (win_we),
    .win_waddr_o    (win_waddr),
    .win_raddr_l_o  (win_raddr_l),
    .win_raddr_r_o  (win_raddr_r),
    .tap_we_o       (tap_we),
    .tap_waddr_o    (tap_waddr),
    .tap_raddr_o    (tap_raddr),
    .mac_ctrl_o     (mac_ctrl),
    .emit_o         (emit_go),
    .result_index_o (seq_index)
  );

  cwfd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WIN_RAM_DEPTH)
  ) u_win_ram (
    .clk_i     (clk_i),
    .we_i      (win_we),
    .waddr_i   (win_waddr),
    .wdata_i   (sample_i),
    .raddr_a_i (win_raddr_l),
    .raddr_b_i (win_raddr_r),
    .rdata_a_o (win_l),
    .rdata_b_o (win_r)
  );

  cwfd_ram #(
    .WIDTH (2 * COEF_BITS),
    .DEPTH (TAP_DEPTH)
  ) u_tap_ram (
    .clk_i     (clk_i),
    .we_i      (tap_we),
    .waddr_i   (tap_waddr),
    .wdata_i   ({coef_re_i, coef_im_i}),
    .raddr_a_i (tap_raddr),
    .raddr_b_i (tap_raddr),
    .rdata_a_o (tap_rd),
    .rdata_b_o (tap_rd_b)
  );

  cwfd_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS),
    .MAX_HALF    (MAX_HALF)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .l_i      ($signed(win_l)),
    .r_i      ($signed(win_r)),
    .re_tap_i ($signed(tap_rd[2*COEF_BITS-1:COEF_BITS])),
    .im_tap_i ($signed(tap_rd_b[COEF_BITS-1:0])),
    .done_o   (mac_done),
    .re_o     (mac_re),
    .im_o     (mac_im),
    .power_o  (mac_power)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      coeff_re_q     <= mac_re;
      coeff_im_q     <= mac_im;
      power_q        <= mac_power;
      result_index_q <= seq_index;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign coeff_re_o     = coeff_re_q;
  assign coeff_im_o     = coeff_im_q;
  assign power_o        = power_q;
  assign result_index_o = result_index_q;

  a_no_write_during_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_ctrl.issue |-> !win_we && !tap_we)
    else $error("Memory written while the tap walk reads it.");

  a_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> !in_ready_o)
    else $error("Accumulation finished while the block takes items.");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(emit_go))
    else $error("Result register filled without a finished result.");

endmodule
